### sv/sel_lex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector lexer package
// Token kinds, lexer phases, character classes and the front/back word type.
// ----------------------------------------------------------------------------
package sel_lex_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OUT_OFF_W       = 16;
  localparam int KIND_W          = 5;
  localparam int FIFO_DEPTH      = 4;

  typedef enum logic [4:0] {
    K_LPAREN = 5'd0, K_RPAREN = 5'd1, K_COMMA = 5'd2, K_PLUS = 5'd3,
    K_MINUS = 5'd4, K_MULT = 5'd5, K_DIV = 5'd6, K_EQUAL = 5'd7,
    K_NEQ = 5'd8, K_LESS = 5'd9, K_GRT = 5'd10, K_LSEQ = 5'd11,
    K_GREQ = 5'd12, K_IDENT = 5'd13, K_STRING = 5'd14, K_EXACT = 5'd15,
    K_APPROX = 5'd16, K_AND = 5'd17, K_BETWEEN = 5'd18, K_ESCAPE = 5'd19,
    K_FALSE = 5'd20, K_IN = 5'd21, K_IS = 5'd22, K_LIKE = 5'd23,
    K_NOT = 5'd24, K_NULL = 5'd25, K_OR = 5'd26, K_TRUE = 5'd27,
    K_END = 5'd28, K_ERROR = 5'd29
  } kind_t;

  typedef enum logic [4:0] {
    P_START, P_LT, P_GT, P_IDENT, P_STR, P_STRQ, P_ZERO, P_DIGIT,
    P_HEXS, P_HEX, P_OCT, P_BINS, P_BIN, P_DECS, P_DEC, P_EXPSIGN,
    P_EXPS, P_EXP
  } phase_t;

  // One word from the front (lexer) to the back (result queue): up to two
  // tokens caused by one input character.
  typedef struct packed {
    logic        two;
    kind_t       kind0;
    logic [31:0] s0;
    logic [31:0] e0;
    kind_t       kind1;
    logic [31:0] s1;
    logic [31:0] e1;
  } tok_pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_fd(input logic [7:0] c);
    return c == "f" || c == "F" || c == "d" || c == "D";
  endfunction
  function automatic logic is_l(input logic [7:0] c);
    return c == "l" || c == "L";
  endfunction
  function automatic logic is_e(input logic [7:0] c);
    return c == "e" || c == "E";
  endfunction
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Reserved-word lookup on lower-cased first seven characters.
  function automatic kind_t word_kind(input logic [55:0] w, input logic [3:0] n);
    kind_t k;
    k = K_IDENT;
    case (n)
      4'd2: begin
        if (w[15:0] == {"n", "i"}) k = K_IN;
        else if (w[15:0] == {"s", "i"}) k = K_IS;
        else if (w[15:0] == {"r", "o"}) k = K_OR;
      end
      4'd3: begin
        if (w[23:0] == {"d", "n", "a"}) k = K_AND;
        else if (w[23:0] == {"t", "o", "n"}) k = K_NOT;
      end
      4'd4: begin
        if (w[31:0] == {"e", "k", "i", "l"}) k = K_LIKE;
        else if (w[31:0] == {"l", "l", "u", "n"}) k = K_NULL;
        else if (w[31:0] == {"e", "u", "r", "t"}) k = K_TRUE;
      end
      4'd5: if (w[39:0] == {"e", "s", "l", "a", "f"}) k = K_FALSE;
      4'd6: if (w[47:0] == {"e", "p", "a", "c", "s", "e"}) k = K_ESCAPE;
      4'd7: if (w == {"n", "e", "e", "w", "t", "e", "b"}) k = K_BETWEEN;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### sv/sel_lex_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector lexer front end
// Lexer FSM: one character a cycle while step is high; up to two tokens each.
// ----------------------------------------------------------------------------
module sel_lex_front #(
  parameter int OFFSET_BITS = sel_lex_pkg::OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            char_byte,
  input  logic                  end_of_text,
  output logic                  tok_valid,
  output sel_lex_pkg::tok_pair_t tok
);
  import sel_lex_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, start_r, start_nxt;
  logic [7:0]           wch_r [7];
  logic [3:0]           wlen_r, wlen_nxt;
  logic                 dq_r, dq_nxt;
  kind_t                pend_r, pend_nxt;
  logic                 err_r, err_nxt;

  logic [OFFSET_BITS-1:0] o, o1;
  logic [1:0]           n;
  kind_t                k [2];
  logic [OFFSET_BITS-1:0] ts [2];
  logic [OFFSET_BITS-1:0] te [2];
  logic                 wr_en;
  logic [2:0]           wr_idx;
  logic [7:0]           wr_char;
  logic [55:0]          wflat;
  kind_t                idk;

  always_comb begin
    for (int i = 0; i < 7; i++) wflat[i*8 +: 8] = wch_r[i];
  end
  assign idk = (wlen_r <= 4'd7) ? word_kind(wflat, wlen_r) : K_IDENT;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  q;
    logic        restart;
    logic        again;
    c = char_byte;
    o = off_r;
    o1 = off_r + 1'b1;
    q = dq_r ? 8'h22 : 8'h27;
    phase_nxt = phase_r;
    start_nxt = start_r;
    wlen_nxt = wlen_r;
    dq_nxt = dq_r;
    pend_nxt = pend_r;
    err_nxt = err_r;
    off_nxt = off_r;
    n = 2'd0;
    k[0] = K_END; k[1] = K_END;
    ts[0] = '0; ts[1] = '0; te[0] = '0; te[1] = '0;
    wr_en = 1'b0; wr_idx = '0; wr_char = to_lower(c);
    restart = 1'b0;
    again = 1'b0;
    if (end_of_text) begin
      if (!err_r) begin
        unique case (phase_r)
          P_START: ;
          P_LT:    begin k[0] = K_LESS; n = 2'd1; end
          P_GT:    begin k[0] = K_GRT; n = 2'd1; end
          P_IDENT: begin k[0] = idk; n = 2'd1; end
          P_STRQ:  begin k[0] = pend_r; n = 2'd1; end
          P_ZERO, P_DIGIT, P_HEX, P_OCT, P_BIN: begin k[0] = K_EXACT; n = 2'd1; end
          P_DEC, P_EXP: begin k[0] = K_APPROX; n = 2'd1; end
          default: begin k[0] = K_ERROR; n = 2'd1; end
        endcase
        ts[0] = start_r; te[0] = o;
      end
      k[n[0]] = K_END; ts[n[0]] = o; te[n[0]] = o;
      n = n + 2'd1;
      phase_nxt = P_START; off_nxt = '0; start_nxt = '0; wlen_nxt = '0;
      dq_nxt = 1'b0; pend_nxt = K_LPAREN; err_nxt = 1'b0;
    end else begin
      off_nxt = o1;
      if (!err_r) begin
        ts[0] = start_r;
        // finish-and-restart: first token ends at o, char restarts lexing
        unique case (phase_r)
          P_START: restart = 1'b1;
          P_LT: begin
            if (c == ">") begin k[0] = K_NEQ; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else if (c == "=") begin k[0] = K_LSEQ; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else begin k[0] = K_LESS; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_GT: begin
            if (c == "=") begin k[0] = K_GREQ; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else begin k[0] = K_GRT; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_" || c == "$" || c == ".") begin
              if (wlen_r < 4'd7) begin wr_en = 1'b1; wr_idx = wlen_r[2:0]; end
              if (wlen_r < 4'd8) wlen_nxt = wlen_r + 4'd1;
            end else begin k[0] = idk; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_STR: if (c == q) phase_nxt = P_STRQ;
          P_STRQ: begin
            if (c == q) phase_nxt = P_STR;
            else begin k[0] = pend_r; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_ZERO: begin
            if (c == ".") phase_nxt = P_DEC;
            else if (c == "x" || c == "X") phase_nxt = P_HEXS;
            else if (c == "b" || c == "B") phase_nxt = P_BINS;
            else again = 1'b1;
          end
          P_OCT: again = 1'b1;
          P_HEXS: begin
            if (is_xdigit(c)) phase_nxt = P_HEX;
            else begin k[0] = K_ERROR; te[0] = o1; n = 2'd1; err_nxt = 1'b1; phase_nxt = P_START; end
          end
          P_HEX: begin
            if (is_l(c)) begin k[0] = K_EXACT; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else if (is_xdigit(c) || c == "_") ;
            else if (c == "p" || c == "P") phase_nxt = P_EXPSIGN;
            else begin k[0] = K_EXACT; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_BINS: begin
            if (c == "0" || c == "1") phase_nxt = P_BIN;
            else begin k[0] = K_ERROR; te[0] = o1; n = 2'd1; err_nxt = 1'b1; phase_nxt = P_START; end
          end
          P_BIN: begin
            if (is_l(c)) begin k[0] = K_EXACT; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else if (c == "0" || c == "1" || c == "_") ;
            else begin k[0] = K_EXACT; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_DIGIT: begin
            if (is_l(c)) begin k[0] = K_EXACT; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else if (is_fd(c)) begin k[0] = K_APPROX; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else if (is_digit(c) || c == "_") ;
            else if (c == ".") phase_nxt = P_DEC;
            else if (is_e(c)) phase_nxt = P_EXPSIGN;
            else begin k[0] = K_EXACT; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_DECS: begin
            if (is_digit(c)) phase_nxt = P_DEC;
            else begin k[0] = K_ERROR; te[0] = o1; n = 2'd1; err_nxt = 1'b1; phase_nxt = P_START; end
          end
          P_DEC: begin
            if (is_digit(c) || c == "_") ;
            else if (is_e(c)) phase_nxt = P_EXPSIGN;
            else if (is_fd(c)) begin k[0] = K_APPROX; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else begin k[0] = K_APPROX; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          P_EXPSIGN: begin
            if (c == "+" || c == "-") phase_nxt = P_EXPS;
            else if (is_digit(c)) phase_nxt = P_EXP;
            else begin k[0] = K_ERROR; te[0] = o1; n = 2'd1; err_nxt = 1'b1; phase_nxt = P_START; end
          end
          P_EXPS: begin
            if (is_digit(c)) phase_nxt = P_EXP;
            else begin k[0] = K_ERROR; te[0] = o1; n = 2'd1; err_nxt = 1'b1; phase_nxt = P_START; end
          end
          P_EXP: begin
            if (is_digit(c)) ;
            else if (is_fd(c)) begin k[0] = K_APPROX; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
            else begin k[0] = K_APPROX; te[0] = o; n = 2'd1; restart = 1'b1; end
          end
          default: restart = 1'b1;
        endcase
        // octal continuation (also entered from a leading zero)
        if (again) begin
          phase_nxt = P_OCT;
          if (is_l(c)) begin k[0] = K_EXACT; te[0] = o1; n = 2'd1; phase_nxt = P_START; end
          else if ((c >= "0" && c <= "7") || c == "_") ;
          else begin k[0] = K_EXACT; te[0] = o; n = 2'd1; restart = 1'b1; end
        end
        if (restart) begin
          start_nxt = o;
          phase_nxt = P_START;
          ts[n[0]] = o; te[n[0]] = o1;
          if (is_space(c)) ;
          else if (c == "(") begin k[n[0]] = K_LPAREN; n = n + 2'd1; end
          else if (c == ")") begin k[n[0]] = K_RPAREN; n = n + 2'd1; end
          else if (c == ",") begin k[n[0]] = K_COMMA; n = n + 2'd1; end
          else if (c == "+") begin k[n[0]] = K_PLUS; n = n + 2'd1; end
          else if (c == "-") begin k[n[0]] = K_MINUS; n = n + 2'd1; end
          else if (c == "*") begin k[n[0]] = K_MULT; n = n + 2'd1; end
          else if (c == "/") begin k[n[0]] = K_DIV; n = n + 2'd1; end
          else if (c == "=") begin k[n[0]] = K_EQUAL; n = n + 2'd1; end
          else if (c == "<") phase_nxt = P_LT;
          else if (c == ">") phase_nxt = P_GT;
          else if (is_alpha(c) || c == "_" || c == "$") begin
            wr_en = 1'b1; wr_idx = '0; wlen_nxt = 4'd1; phase_nxt = P_IDENT;
          end else if (c == 8'h27 || c == 8'h22) begin
            dq_nxt = (c == 8'h22);
            pend_nxt = (c == 8'h22) ? K_IDENT : K_STRING;
            phase_nxt = P_STR;
          end else if (c == "0") phase_nxt = P_ZERO;
          else if (is_digit(c)) phase_nxt = P_DIGIT;
          else if (c == ".") phase_nxt = P_DECS;
          else begin
            k[n[0]] = K_ERROR; ts[n[0]] = o; n = n + 2'd1; err_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    tok_valid = step && (n != 2'd0);
    tok.two   = (n == 2'd2);
    tok.kind0 = k[0];
    tok.kind1 = k[1];
    tok.s0 = 32'(ts[0]); tok.e0 = 32'(te[0]);
    tok.s1 = 32'(ts[1]); tok.e1 = 32'(te[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_START; off_r <= '0; start_r <= '0; wlen_r <= '0;
      dq_r <= 1'b0; pend_r <= K_LPAREN; err_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; off_r <= off_nxt; start_r <= start_nxt;
      wlen_r <= wlen_nxt; dq_r <= dq_nxt; pend_r <= pend_nxt; err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) wch_r[wr_idx] <= wr_char;
  end

endmodule

### sv/sel_lex_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector lexer back end
// Token-pair queue; serializes each pair into one or two result words.
// ----------------------------------------------------------------------------
module sel_lex_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr,
  input  sel_lex_pkg::tok_pair_t wr_data,
  output logic                   nearly_full,
  output logic                   empty,
  input  logic                   pop,
  output logic [4:0]             token_kind,
  output logic [15:0]            token_start,
  output logic [15:0]            token_end,
  output logic                   last_of_run
);
  import sel_lex_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  tok_pair_t      q_r [FIFO_DEPTH];
  logic [AW-1:0]  rd_r, wr_r;
  logic [AW:0]    cnt_r;
  logic           sub_r;
  tok_pair_t      head;
  logic           pop_pair;

  assign head        = q_r[rd_r];
  assign empty       = (cnt_r == '0);
  // front writes at the accepting edge; no room once every slot holds a pair
  assign nearly_full = (cnt_r == (AW+1)'(FIFO_DEPTH));
  assign token_kind  = sub_r ? head.kind1 : head.kind0;
  assign token_start = sub_r ? head.s1[15:0] : head.s0[15:0];
  assign token_end   = sub_r ? head.e1[15:0] : head.e0[15:0];
  assign last_of_run = sub_r || !head.two;
  assign pop_pair    = pop && !empty && last_of_run;

  always_ff @(posedge clk) begin
    if (wr) q_r[wr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0; sub_r <= 1'b0;
    end else begin
      if (wr) wr_r <= wr_r + 1'b1;
      if (pop_pair) rd_r <= rd_r + 1'b1;
      if (pop && !empty) sub_r <= !last_of_run;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(pop_pair);
    end
  end

endmodule

### sv/selector_expression_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selector expression lexer
// Streaming message-selector tokenizer; one character a cycle unless full.
// ----------------------------------------------------------------------------
// Output: a token word enters the back-end queue when the character that
//   completes it is accepted, and shows on the out_ ports at the queue head.
// Throughput: one character per cycle unless full; set by the lexer step.
//   Results drain at one word per cycle while pop is high, so a character
//   that yields two tokens gives two result words on the output side.
// Reset: synchronous active-low rst_n returns the lexer to its start phase,
//   clears offsets and empties the token queue.
// ----------------------------------------------------------------------------
module selector_expression_lexer #(
  parameter int OFFSET_BITS = sel_lex_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_end,
  output logic        out_last_of_run
);
  import sel_lex_pkg::*;

  logic      step;
  logic      tok_valid;
  tok_pair_t tok;
  logic      nearly_full;

  // The front steps on every accepted character; its token pair goes into
  // the back-end queue at the same edge. full rises once every slot holds
  // a pair.
  assign full = nearly_full;
  assign step = push && !full;

  sel_lex_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .step,
    .char_byte  (in_char_byte),
    .end_of_text(in_end_of_text),
    .tok_valid, .tok
  );

  sel_lex_back u_back (
    .clk, .rst_n,
    .wr         (tok_valid),
    .wr_data    (tok),
    .nearly_full,
    .empty,
    .pop,
    .token_kind (out_token_kind),
    .token_start(out_token_start),
    .token_end  (out_token_end),
    .last_of_run(out_last_of_run)
  );

  // The end marker always yields at least one result word.
  a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_end_of_text) |=> !empty) else $error("no result after end marker");

  // An END token always closes its run.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_kind == K_END) |-> out_last_of_run)
    else $error("END not last of run");

  // Kinds stay in the defined range.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_token_kind <= K_ERROR)) else $error("bad token kind");

endmodule
